FILE: src/sppid_pkg.sv
// Shared types and constants for the servo position PID step block.
// Used by the top level and the constant divider unit; no dependencies.
package sppid_pkg;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_STOPPED = 2'd1,
		ST_FAULT   = 2'd2
	} status_t;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t CFG_GAIN_P      = 3'd0;
	localparam cfg_index_t CFG_GAIN_I      = 3'd1;
	localparam cfg_index_t CFG_GAIN_D      = 3'd2;
	localparam cfg_index_t CFG_GAIN_FF_VEL = 3'd3;
	localparam cfg_index_t CFG_GAIN_FF_ACC = 3'd4;
	localparam cfg_index_t CFG_DEADBAND    = 3'd5;
	localparam cfg_index_t CFG_FAULT_LIMIT = 3'd6;

	// ceil(2^35 / 10); with a right shift of 35 this divides any 32-bit
	// magnitude by ten exactly, and with a shift of 36 by twenty.
	localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;
	localparam int          TEN_SHIFT = 35;

endpackage

FILE: src/sppid_divc.sv
// Signed division by a constant, truncating toward zero, as one multiply stage.
// Depends on sppid_pkg for the reciprocal; the quotient follows the product register.
module sppid_divc #(
	parameter int SHIFT = 35
) (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] num,
	output logic [31:0] quo
);
	import sppid_pkg::*;

	logic [31:0] mag;
	logic [63:0] prod;
	logic [63:0] prod_s1;
	logic        neg_s1;
	logic [31:0] quo_mag;

	assign mag  = num[31] ? (32'd0 - num) : num;
	assign prod = {32'd0, mag} * {32'd0, RECIP_TEN};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			neg_s1  <= num[31];
		end
	end

	assign quo_mag = 32'(prod_s1 >> SHIFT);
	assign quo     = neg_s1 ? (32'd0 - quo_mag) : quo_mag;

endmodule

FILE: src/servo_position_pid_step.sv
// Servo position PID step: top level with configuration registers and pipeline.
// Depends on sppid_pkg and sppid_divc.
//
// Usage: each control tick is one item on the input channel (encoder_count,
// requested_position, run_enable), taken when in_valid is high and in_stall
// is low. Every item gives exactly one result item on the output channel
// (status, drive, duty, direction, peak_error), taken when out_valid is high
// and out_stall is low. Gains, deadband and fault limit are written through
// the cfg channel (cfg_ready is always high) while no item is in flight.
// Throughput is one item per cycle while the receiver does not stall; the
// integrator update is an add and clamp loop in stage C, stage A keeps the
// error, command and peak state, and every other stage is a feed-forward register.
// Five gain multipliers work in parallel in one stage, and the divisions by
// twenty and ten each take a reciprocal multiply stage.
// Reset clears the pipeline, the controller state, the held drive outputs and
// loads the register reset values. When the receiver stalls with a result
// waiting, the whole pipeline holds and in_stall rises in the same cycle.
module servo_position_pid_step #(
	parameter int INTEGRATOR_LIMIT = 1048576,
	parameter int DUTY_LIMIT       = 4095
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  sppid_pkg::cfg_index_t  cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [15:0]     encoder_count,
	input  logic signed [31:0]     requested_position,
	input  logic                   run_enable,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic signed [12:0]     drive,
	output logic [11:0]            duty,
	output logic                   direction,
	output logic [31:0]            peak_error
);
	import sppid_pkg::*;

	localparam logic signed [31:0] ILIM = 32'(INTEGRATOR_LIMIT);
	localparam logic signed [31:0] DLIM = 32'(DUTY_LIMIT);

	// Configuration registers
	logic [15:0] gain_p_q, gain_i_q, gain_d_q, gain_ffv_q, gain_ffa_q;
	logic [15:0] deadband_q, fault_limit_q;

	// Controller state
	logic [31:0] integ_q, prev_err_q, prev_cmd_q, prev_delta_q, peak_q;

	logic adv;

	// Stage 1: input register
	logic        valid_s1;
	logic [15:0] enc_s1;
	logic [31:0] req_s1;
	logic        run_s1;

	// Stage A logic
	logic [31:0] enc_ext, err_a, abs_a, db_a, errd_a, ediff_a, delta_a, delta2_a, peak_a;
	logic        fault_a;
	status_t     status_a;

	// Stage 2
	logic        valid_s2;
	status_t     status_s2;
	logic [31:0] errd_s2, ediff_s2, delta_s2, delta2_s2, peak_s2;

	// Stage 3
	logic        valid_s3;
	status_t     status_s3;
	logic [31:0] pp_s3, pi_s3, pd_s3, pv_s3, pa_s3, peak_s3;

	// Stage C logic
	logic [31:0] isum_c, acc_c, sum4_c;

	// Stage 4
	logic        valid_s4;
	status_t     status_s4;
	logic [31:0] acc_s4, sum4_s4, peak_s4;

	// Stage 5
	logic        valid_s5;
	status_t     status_s5;
	logic [31:0] sum4_s5, peak_s5, q20, total_e;

	// Stage 6
	logic        valid_s6;
	status_t     status_s6;
	logic [31:0] peak_s6, q10;

	// Stage F logic
	logic signed [31:0] res_f, clamp_f, mag_f;

	// Output register and held drive state
	logic               out_valid_q;
	status_t            out_status_q;
	logic [31:0]        out_peak_q;
	logic signed [12:0] held_drive_q;
	logic [11:0]        held_duty_q;
	logic               held_dir_q;

	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= 16'd100;
			gain_i_q      <= 16'd0;
			gain_d_q      <= 16'd0;
			gain_ffv_q    <= 16'd0;
			gain_ffa_q    <= 16'd0;
			deadband_q    <= 16'd0;
			fault_limit_q <= 16'd600;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GAIN_P:      gain_p_q      <= cfg_data;
				CFG_GAIN_I:      gain_i_q      <= cfg_data;
				CFG_GAIN_D:      gain_d_q      <= cfg_data;
				CFG_GAIN_FF_VEL: gain_ffv_q    <= cfg_data;
				CFG_GAIN_FF_ACC: gain_ffa_q    <= cfg_data;
				CFG_DEADBAND:    deadband_q    <= cfg_data;
				CFG_FAULT_LIMIT: fault_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits for all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			out_valid_q <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			enc_s1 <= encoder_count;
			req_s1 <= requested_position;
			run_s1 <= run_enable;
		end
	end

	// Stage A: error, deadband, command deltas, peak and fault check
	always_comb begin
		enc_ext  = {{16{enc_s1[15]}}, enc_s1};
		err_a    = enc_ext - req_s1;
		delta_a  = req_s1 - prev_cmd_q;
		delta2_a = delta_a - prev_delta_q;
		abs_a    = err_a[31] ? (32'd0 - err_a) : err_a;
		db_a     = {16'd0, deadband_q};
		if (abs_a < db_a) begin
			errd_a = 32'd0;
		end else if (!err_a[31] && err_a != 32'd0) begin
			errd_a = err_a - db_a;
		end else begin
			errd_a = err_a + db_a;
		end
		ediff_a = errd_a - prev_err_q;
		fault_a = abs_a > {16'd0, fault_limit_q};
		peak_a  = (abs_a > peak_q) ? abs_a : peak_q;
		if (!run_s1) begin
			status_a = ST_STOPPED;
		end else if (fault_a) begin
			status_a = ST_FAULT;
		end else begin
			status_a = ST_UPDATED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cmd_q   <= 32'd0;
			prev_delta_q <= 32'd0;
			prev_err_q   <= 32'd0;
			peak_q       <= 32'd0;
		end else if (adv && valid_s1 && run_s1) begin
			prev_cmd_q   <= req_s1;
			prev_delta_q <= delta_a;
			peak_q       <= peak_a;
			if (!fault_a) begin
				prev_err_q <= errd_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_a;
			errd_s2   <= errd_a;
			ediff_s2  <= ediff_a;
			delta_s2  <= delta_a;
			delta2_s2 <= delta2_a;
			peak_s2   <= run_s1 ? peak_a : peak_q;
		end
	end

	// Stage B: gain products, wrapping at 32 bits
	always_ff @(posedge clk) begin
		if (adv) begin
			status_s3 <= status_s2;
			peak_s3   <= peak_s2;
			pp_s3     <= errd_s2 * {16'd0, gain_p_q};
			pi_s3     <= errd_s2 * {16'd0, gain_i_q};
			pd_s3     <= ediff_s2 * {16'd0, gain_d_q};
			pv_s3     <= delta_s2 * {16'd0, gain_ffv_q};
			pa_s3     <= delta2_s2 * {16'd0, gain_ffa_q};
		end
	end

	// Stage C: integrator with clamp, sum of the other terms
	always_comb begin
		isum_c = integ_q + pi_s3;
		if ($signed(isum_c) > ILIM) begin
			acc_c = ILIM;
		end else if ($signed(isum_c) < -ILIM) begin
			acc_c = -ILIM;
		end else begin
			acc_c = isum_c;
		end
		sum4_c = pp_s3 + pd_s3 + pv_s3 + pa_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= 32'd0;
		end else if (adv && valid_s3) begin
			if (status_s3 == ST_STOPPED) begin
				integ_q <= 32'd0;
			end else if (status_s3 == ST_UPDATED) begin
				integ_q <= acc_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s4 <= status_s3;
			peak_s4   <= peak_s3;
			acc_s4    <= acc_c;
			sum4_s4   <= sum4_c;
		end
	end

	// Stage D: integral term divided by twenty
	sppid_divc #(.SHIFT(TEN_SHIFT + 1)) u_div20 (
		.clk (clk),
		.en  (adv),
		.num (acc_s4),
		.quo (q20)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s5 <= status_s4;
			peak_s5   <= peak_s4;
			sum4_s5   <= sum4_s4;
		end
	end

	// Stage E: full sum divided by ten
	assign total_e = sum4_s5 + q20;

	sppid_divc #(.SHIFT(TEN_SHIFT)) u_div10 (
		.clk (clk),
		.en  (adv),
		.num (total_e),
		.quo (q10)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s6 <= status_s5;
			peak_s6   <= peak_s5;
		end
	end

	// Stage F: clamp to the duty limit, split into direction and magnitude
	always_comb begin
		res_f = $signed(q10);
		if (res_f > DLIM) begin
			clamp_f = DLIM;
		end else if (res_f < -DLIM) begin
			clamp_f = -DLIM;
		end else begin
			clamp_f = res_f;
		end
		mag_f = clamp_f[31] ? -clamp_f : clamp_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_drive_q <= '0;
			held_duty_q  <= '0;
			held_dir_q   <= 1'b0;
			out_peak_q   <= 32'd0;
			out_status_q <= ST_UPDATED;
		end else if (adv && valid_s6) begin
			out_status_q <= status_s6;
			out_peak_q   <= peak_s6;
			if (status_s6 == ST_UPDATED) begin
				held_drive_q <= clamp_f[12:0];
				held_duty_q  <= mag_f[11:0];
				held_dir_q   <= (clamp_f > 32'sd0) ? 1'b0 : 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign drive      = held_drive_q;
	assign duty       = held_duty_q;
	assign direction  = held_dir_q;
	assign peak_error = out_peak_q;

endmodule

FILE: src/sppid_check.sv
// Port-level checks for the servo position PID step block, bound to its top level.
// Depends on sppid_pkg for the status codes.
module sppid_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic signed [12:0] drive,
	input logic [31:0]        peak_error
);
	import sppid_pkg::*;

	// The input side only waits when a finished result is held up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) &&
			$stable(drive) && $stable(peak_error)))
		else $error("stalled result changed");

	// Drive moves only with a result that reports an update.
	a_drive_held: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(drive) |-> (out_valid && status == ST_UPDATED))
		else $error("drive changed without an updated result");

	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		peak_error >= $past(peak_error))
		else $error("peak error decreased");

endmodule

bind servo_position_pid_step sppid_check u_sppid_check (.*);

FILE: bench/tb_top.sv
// Self-checking bench for servo_position_pid_step: a clocked driver, a clocked
// monitor and a bit-exact predictor of the PID tick, under several gain settings.
// Depends on sppid_pkg and the servo_position_pid_step RTL.
module tb_top;
	import sppid_pkg::*;

	localparam int INTEG_LIMIT = 1048576;
	localparam int DRIVE_LIMIT = 4095;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_TICKS = 190;
	localparam int RUN_LIMIT   = 3000000;
	localparam cfg_index_t CFG_UNUSED = 3'd7;

	typedef struct {
		logic signed [15:0] enc;
		logic signed [31:0] req;
		logic               run;
	} tick_in_t;

	typedef struct {
		status_t            status;
		logic signed [12:0] drive;
		logic [11:0]        duty;
		logic               direction;
		logic [31:0]        peak;
	} tick_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_index_t cfg_index = CFG_GAIN_P;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] encoder_count = '0;
	logic signed [31:0] requested_position = '0;
	logic run_enable = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [12:0] drive;
	logic [11:0] duty;
	logic direction;
	logic [31:0] peak_error;

	tick_in_t  ticks_to_send[$];
	tick_out_t tick_results_due[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_granted = 0;
	int hold_left = 0;
	int limit_in_use = 600;
	int mismatches = 0;
	int results_seen = 0;

	// Predictor copy of the registers and of the controller state.
	logic [31:0] k_p, k_i, k_d, k_vel, k_acc, dead_zone, err_limit;
	int          integ_acc;
	logic [31:0] last_err, last_cmd, last_cmd_step, peak_abs;
	logic [11:0] hold_duty;
	logic        hold_dir;
	logic [12:0] hold_drive;

	servo_position_pid_step #(
		.INTEGRATOR_LIMIT(INTEG_LIMIT),
		.DUTY_LIMIT(DRIVE_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.encoder_count(encoder_count),
		.requested_position(requested_position),
		.run_enable(run_enable),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.drive(drive),
		.duty(duty),
		.direction(direction),
		.peak_error(peak_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_controller();
		k_p = 100; k_i = 0; k_d = 0; k_vel = 0; k_acc = 0;
		dead_zone = 0; err_limit = 600;
		integ_acc = 0;
		last_err = '0; last_cmd = '0; last_cmd_step = '0; peak_abs = '0;
		hold_duty = '0; hold_dir = 1'b0; hold_drive = '0;
	endfunction

	function automatic tick_out_t servo_tick(logic signed [15:0] enc, logic signed [31:0] req,
			logic run);
		tick_out_t r;
		logic [31:0] e32, err, cmd_step, cmd_step2, mag, total;
		int acc, iterm, cmd_out;
		e32 = {{16{enc[15]}}, enc};
		r.status = ST_UPDATED;
		if (!run) begin
			integ_acc = 0;
			r.status = ST_STOPPED;
		end else begin
			err = e32 - req;
			cmd_step = req - last_cmd;
			cmd_step2 = cmd_step - last_cmd_step;
			mag = err[31] ? -err : err;
			last_cmd = req;
			last_cmd_step = cmd_step;
			if (mag < dead_zone) begin
				err = '0;
			end else if (!err[31] && err != 0) begin
				err = err - dead_zone;
			end else begin
				err = err + dead_zone;
			end
			if (mag > peak_abs)
				peak_abs = mag;
			if (mag > err_limit) begin
				r.status = ST_FAULT;
			end else begin
				acc = integ_acc + err * k_i;
				if (acc > INTEG_LIMIT)
					acc = INTEG_LIMIT;
				else if (acc < -INTEG_LIMIT)
					acc = -INTEG_LIMIT;
				integ_acc = acc;
				// Kept apart so the division stays signed and truncates toward zero.
				iterm = acc / 20;
				total = err * k_p + iterm + (err - last_err) * k_d
					+ cmd_step * k_vel + cmd_step2 * k_acc;
				last_err = err;
				cmd_out = $signed(total) / 10;
				if (cmd_out > DRIVE_LIMIT)
					cmd_out = DRIVE_LIMIT;
				else if (cmd_out < -DRIVE_LIMIT)
					cmd_out = -DRIVE_LIMIT;
				hold_dir = (cmd_out > 0) ? 1'b0 : 1'b1;
				hold_duty = 12'((cmd_out < 0) ? -cmd_out : cmd_out);
				hold_drive = cmd_out[12:0];
			end
		end
		r.drive = hold_drive;
		r.duty = hold_duty;
		r.direction = hold_dir;
		r.peak = peak_abs;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("result %0d: %s is %0h, expected %0h", results_seen, field, got, want);
		mismatches++;
	endtask

	// Predictor: follows register writes and every accepted item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAIN_P:      k_p = {16'd0, cfg_data};
					CFG_GAIN_I:      k_i = {16'd0, cfg_data};
					CFG_GAIN_D:      k_d = {16'd0, cfg_data};
					CFG_GAIN_FF_VEL: k_vel = {16'd0, cfg_data};
					CFG_GAIN_FF_ACC: k_acc = {16'd0, cfg_data};
					CFG_DEADBAND:    dead_zone = {16'd0, cfg_data};
					CFG_FAULT_LIMIT: err_limit = {16'd0, cfg_data};
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				tick_results_due.push_back(servo_tick(encoder_count, requested_position,
					run_enable));
		end
	end

	// Driver: a new item is offered only once the previous one has been taken.
	always @(posedge clk) begin : drive_ticks
		tick_in_t nxt;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (ticks_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = ticks_to_send.pop_front();
				in_valid <= 1'b1;
				encoder_count <= nxt.enc;
				requested_position <= nxt.req;
				run_enable <= nxt.run;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here so the random stall keeps its own process.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_granted) begin
			hold_left <= HOLD_CYCLES;
			hold_granted <= hold_granted + 1;
		end
	end

	always @(posedge clk) begin
		out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		tick_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (tick_results_due.size() == 0) begin
				flag_mismatch("unexpected item", 32'(status), '0);
			end else begin
				want = tick_results_due.pop_front();
				if (status !== want.status)
					flag_mismatch("status", 32'(status), 32'(want.status));
				if (drive !== want.drive)
					flag_mismatch("drive", 32'(drive), 32'(want.drive));
				if (duty !== want.duty)
					flag_mismatch("duty", 32'(duty), 32'(want.duty));
				if (direction !== want.direction)
					flag_mismatch("direction", 32'(direction), 32'(want.direction));
				if (peak_error !== want.peak)
					flag_mismatch("peak_error", peak_error, want.peak);
			end
		end
	end

	task automatic queue_tick(input int enc, input logic [31:0] req, input logic run);
		tick_in_t t;
		t.enc = 16'(enc);
		t.req = req;
		t.run = run;
		ticks_to_send.push_back(t);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (ticks_to_send.size() != 0 || in_valid || tick_results_due.size() != 0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_gains(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
			input logic [15:0] v, input logic [15:0] a, input logic [15:0] db,
			input logic [15:0] lim);
		write_reg(CFG_GAIN_P, p);
		write_reg(CFG_GAIN_I, i);
		write_reg(CFG_GAIN_D, d);
		write_reg(CFG_GAIN_FF_VEL, v);
		write_reg(CFG_GAIN_FF_ACC, a);
		write_reg(CFG_DEADBAND, db);
		write_reg(CFG_FAULT_LIMIT, lim);
		limit_in_use = int'(lim);
		@(negedge clk);
	endtask

	initial begin
		#RUN_LIMIT;
		$display("servo_position_pid_step regression: fail");
		$finish;
	end

	initial begin
		int cmd, off, span, e, sel;
		clear_controller();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset register values.
		queue_tick(0, 0, 1'b0);
		queue_tick(100, 0, 1'b1);
		queue_tick(-100, 0, 1'b1);
		queue_tick(600, 0, 1'b1);
		queue_tick(-601, 0, 1'b1);
		queue_tick(0, 0, 1'b1);
		queue_tick(32767, 32767, 1'b1);
		queue_tick(-32768, -32768, 1'b1);
		// Most negative error: its magnitude is two to the 31st.
		queue_tick(0, 32'h8000_0000, 1'b1);
		queue_tick(32767, 32'h8000_0000, 1'b1);
		queue_tick(-32768, 32'h7FFF_FFFF, 1'b0);
		queue_tick(5, 5, 1'b1);
		wait_idle();

		// All gains at their maximum, so products wrap and the integrator clamps.
		load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10, 16'hFFFF);
		write_reg(CFG_UNUSED, 16'h1234);
		@(negedge clk);
		queue_tick(5, 0, 1'b1);
		queue_tick(10, 0, 1'b1);
		queue_tick(-30, 0, 1'b1);
		queue_tick(300, 0, 1'b1);
		queue_tick(300, 0, 1'b1);
		queue_tick(-300, 0, 1'b1);
		queue_tick(1000, 1000, 1'b1);
		queue_tick(-32768, -32768, 1'b1);
		queue_tick(0, 0, 1'b0);
		queue_tick(40, 0, 1'b1);
		wait_idle();

		cmd = 0;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: load_gains(100, 0, 0, 0, 0, 0, 600);
				1: load_gains(0, 0, 0, 0, 0, 0, 0);
				2: load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'hFFFF);
				3: load_gains(200, 50, 800, 20, 10, 5, 1500);
				5: load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
				6: load_gains(30, 400, 0, 0, 0, 0, 5000);
				default: load_gains(16'($urandom_range(0, 300)), 16'($urandom_range(0, 100)),
					16'($urandom_range(0, 1500)), 16'($urandom_range(0, 40)),
					16'($urandom_range(0, 40)), 16'($urandom_range(0, 30)),
					16'($urandom_range(100, 3000)));
			endcase
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 76; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 76; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			span = (limit_in_use + 20 > 40000) ? 40000 : limit_in_use + 20;
			for (int n = 0; n < PHASE_TICKS; n++) begin
				sel = $urandom_range(99);
				if (sel < 8) begin
					queue_tick($urandom_range(0, 65535), $urandom, 1'b0);
				end else if (sel < 20) begin
					queue_tick($urandom_range(0, 65535), $urandom, 1'b1);
				end else begin
					// A slowly moving command with the encoder trailing near it.
					cmd = cmd + $urandom_range(0, 40) - 20;
					if (cmd > 30000)
						cmd = 30000;
					else if (cmd < -30000)
						cmd = -30000;
					if ($urandom_range(4) == 0)
						off = $urandom_range(0, 6) - 3;
					else
						off = $urandom_range(0, 2 * span) - span;
					e = cmd + off;
					if (e > 32767)
						e = 32767;
					else if (e < -32768)
						e = -32768;
					queue_tick(e, cmd, 1'b1);
				end
				// Halfway through, let every result drain before going on.
				if (n == PHASE_TICKS / 2 - 1) begin
					if (p == 0) begin
						while (ticks_to_send.size() > PHASE_TICKS / 2 - 20)
							@(negedge clk);
						hold_asked++;
					end
					wait_idle();
				end
			end
			wait_idle();
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("servo_position_pid_step regression: pass");
		else
			$display("servo_position_pid_step regression: fail");
		$finish;
	end

endmodule

FILE: servo_position_pid_step.f
src/sppid_pkg.sv
src/sppid_divc.sv
src/servo_position_pid_step.sv
src/sppid_check.sv
bench/tb_top.sv
